// File: rtl/cba_pkg.sv
// shared types, constants and angle table for the compass bearing pipeline
package cba_pkg;

    // configuration of the datapath
    localparam int COORD_BITS      = 16;
    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 7;

    localparam int FIELD_W   = 16;
    localparam int TABLE_LEN = 24;
    localparam int VEC_GUARD = 24;
    localparam int STEPS     = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

    // coordinate difference, cordic vector and angle accumulator widths
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int VEC_W  = DIFF_W + VEC_GUARD + 3;
    localparam int ANG_W  = 50;
    localparam int BEAR_W = 49;

    // rounding divide of the bearing in picodegrees down to the output unit
    localparam int QUOT_W = 9 + ANGLE_FRAC_BITS;
    localparam int NUM_W  = 50 + ANGLE_FRAC_BITS;

    localparam logic [63:0] HALF_PDEG    = 64'd500000000000;

    // one degree is 2^12 * 5^12 picodegrees: drop 12 bits, then divide by 5^12
    localparam int          PDEG_POW2 = 12;
    localparam int          ODD_W     = 28;
    localparam logic [63:0] PDEG_ODD  = 64'd244140625;

    // quotient estimate: top bits of the shifted numerator times floor(2^52 / 5^12),
    // shifted down by 32; lands on the quotient or one below it
    localparam int          RECIP_SH  = 20;
    localparam int          RECIP_Q   = 32;
    localparam int          RECIP_W   = 25;
    localparam logic [63:0] RECIP     = 64'd18446744;

    localparam logic signed [ANG_W-1:0] DEG90  = ANG_W'(64'sd90000000000000);
    localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(64'sd180000000000000);
    localparam logic signed [ANG_W-1:0] DEG450 = ANG_W'(64'sd450000000000000);

    localparam int OUT_W = 16;

    // atan(2^-i) in picodegrees
    localparam logic [63:0] ATAN_PDEG [TABLE_LEN] = '{
        64'd45000000000000, 64'd26565051177078, 64'd14036243467926, 64'd7125016348902,
        64'd3576334374997,  64'd1789910608246,  64'd895173710211,   64'd447614170861,
        64'd223810500369,   64'd111905677066,   64'd55952891894,    64'd27976452617,
        64'd13988227142,    64'd6994113675,     64'd3497056851,     64'd1748528427,
        64'd874264214,      64'd437132107,      64'd218566053,      64'd109283027,
        64'd54641513,       64'd27320757,       64'd13660378,       64'd6830189
    };

    // valid bit and coincident-point flag that ride along with each item
    typedef struct packed {
        logic valid;
        logic same;
    } t_tag;

endpackage

// File: rtl/cba_front.sv
// difference, half-turn pre-rotation and unrolled cordic vectoring stages
module cba_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [4*cba_pkg::FIELD_W-1:0]       i_data,
    output cba_pkg::t_tag                       o_tag,
    output logic signed [cba_pkg::ANG_W-1:0]    o_z
);

    localparam int DW = cba_pkg::DIFF_W;
    localparam int VW = cba_pkg::VEC_W;
    localparam int AW = cba_pkg::ANG_W;
    localparam int FW = cba_pkg::FIELD_W;
    localparam int NS = cba_pkg::STEPS;

    // low coord bits, sign extended from the top one
    function automatic logic signed [DW-1:0] coord_ext(input logic [FW-1:0] raw);
        logic [cba_pkg::COORD_BITS+FW-1:0] wide;
        logic [cba_pkg::COORD_BITS-1:0]    v;
        wide = {{cba_pkg::COORD_BITS{1'b0}}, raw};
        v    = wide[cba_pkg::COORD_BITS-1:0];
        return {v[cba_pkg::COORD_BITS-1], v};
    endfunction

    logic signed [DW-1:0] fx, fy, tx, ty, dx, dy, xa, ya;
    logic                 neg;

    logic signed [VW-1:0] r_x [NS+1];
    logic signed [VW-1:0] r_y [NS+1];
    logic signed [AW-1:0] r_z [NS+1];
    cba_pkg::t_tag        r_tag [NS+1];

    always_comb begin
        fx  = coord_ext(i_data[FW-1:0]);
        fy  = coord_ext(i_data[2*FW-1:FW]);
        tx  = coord_ext(i_data[3*FW-1:2*FW]);
        ty  = coord_ext(i_data[4*FW-1:3*FW]);
        dx  = fx - tx;
        dy  = ty - fy;
        neg = dx[DW-1];
        xa  = neg ? -dx : dx;
        ya  = neg ? -dy : dy;
    end

    // entry stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0] <= '0;
        end else if (i_en) begin
            r_tag[0].valid <= i_valid;
            r_tag[0].same  <= (dx == '0) && (dy == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= {{3{xa[DW-1]}}, xa, {cba_pkg::VEC_GUARD{1'b0}}};
            r_y[0] <= {{3{ya[DW-1]}}, ya, {cba_pkg::VEC_GUARD{1'b0}}};
            r_z[0] <= neg ? cba_pkg::DEG180 : '0;
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < NS; i++) begin : g_step
        localparam logic signed [AW-1:0] ATAN = AW'(cba_pkg::ATAN_PDEG[i]);
        logic signed [VW-1:0] xs, ys;
        logic                 up;

        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;
        // zero residue turns counterclockwise like a negative one
        assign up = !r_y[i][VW-1] && (r_y[i] != '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[i+1] <= '0;
            end else if (i_en) begin
                r_tag[i+1] <= r_tag[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1] <= up ? r_x[i] + ys : r_x[i] - ys;
                r_y[i+1] <= up ? r_y[i] - xs : r_y[i] + xs;
                r_z[i+1] <= up ? r_z[i] + ATAN : r_z[i] - ATAN;
            end
        end
    end

    assign o_tag = r_tag[NS];
    assign o_z   = r_z[NS];

endmodule

// File: rtl/cba_div.sv
// bearing wrap, half-unit rounding and pipelined divide down to the output unit
module cba_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  cba_pkg::t_tag                       i_tag,
    input  logic signed [cba_pkg::ANG_W-1:0]    i_z,
    output cba_pkg::t_tag                       o_tag,
    output logic [cba_pkg::QUOT_W-1:0]          o_quot
);

    localparam int AW = cba_pkg::ANG_W;
    localparam int BW = cba_pkg::BEAR_W;
    localparam int NW = cba_pkg::NUM_W;
    localparam int QW = cba_pkg::QUOT_W;
    localparam int SW = NW - cba_pkg::PDEG_POW2;
    localparam int HW = SW - cba_pkg::RECIP_SH;
    localparam int PW = HW + cba_pkg::RECIP_W;
    localparam int OD = cba_pkg::ODD_W;
    localparam logic [SW-1:0] ODD = SW'(cba_pkg::PDEG_ODD);

    logic signed [AW-1:0] b_wrap;
    logic [SW-1:0]        n_sh;
    logic [PW-1:0]        prod_est;
    logic [SW-1:0]        back;
    logic [SW-1:0]        rem;

    logic [BW-1:0]   r_b;
    logic [NW-1:0]   r_num;
    logic [SW-1:0]   r_n;
    logic [QW-1:0]   r_qe;
    logic [QW-1:0]   r_qd;
    logic [OD:0]     r_rem;
    logic [QW-1:0]   r_quot;
    cba_pkg::t_tag   r_tag [5];

    // 90 deg minus angle, folded into one turn; angle stays within a turn of 90 deg
    assign b_wrap = (i_z > cba_pkg::DEG90) ? cba_pkg::DEG450 - i_z : cba_pkg::DEG90 - i_z;

    // divide by one degree: power-of-two part is a shift, odd part a reciprocal estimate
    assign n_sh     = r_num[NW-1:cba_pkg::PDEG_POW2];
    assign prod_est = PW'(n_sh[SW-1:cba_pkg::RECIP_SH]) * PW'(cba_pkg::RECIP);
    // remainder of the estimate is below twice the divisor
    assign back     = SW'(r_qe) * ODD;
    assign rem      = r_n - back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0] <= '0;
            r_tag[1] <= '0;
            r_tag[2] <= '0;
            r_tag[3] <= '0;
            r_tag[4] <= '0;
        end else if (i_en) begin
            r_tag[0] <= i_tag;
            r_tag[1] <= r_tag[0];
            r_tag[2] <= r_tag[1];
            r_tag[3] <= r_tag[2];
            r_tag[4] <= r_tag[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b    <= b_wrap[BW-1:0];
            r_num  <= (NW'(r_b) << cba_pkg::ANGLE_FRAC_BITS) + NW'(cba_pkg::HALF_PDEG);
            r_n    <= n_sh;
            r_qe   <= prod_est[cba_pkg::RECIP_Q +: QW];
            r_qd   <= r_qe;
            r_rem  <= rem[OD:0];
            // one correction step brings the estimate up to the quotient
            r_quot <= r_qd + QW'(r_rem >= (OD+1)'(cba_pkg::PDEG_ODD));
        end
    end

    assign o_tag  = r_tag[4];
    assign o_quot = r_quot;

endmodule

// File: rtl/cba_out.sv
// full-turn fold, coincident override, output register and skid stage
module cba_out (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cba_pkg::t_tag                   i_tag,
    input  logic [cba_pkg::QUOT_W-1:0]      i_quot,
    output logic                            o_en,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [cba_pkg::OUT_W-1:0]       o_bearing,
    output logic                            o_same
);

    localparam int QW = cba_pkg::QUOT_W;
    localparam int OW = cba_pkg::OUT_W;
    localparam logic [QW-1:0] TURN = QW'(360) << cba_pkg::ANGLE_FRAC_BITS;

    logic [QW-1:0] q_fold;
    logic [OW-1:0] bear_in;

    logic          r_out_valid, r_skid_valid;
    logic [OW-1:0] r_out_bear, r_skid_bear;
    logic          r_out_same, r_skid_same;
    logic          take_in, load_out, load_skid, drain_skid;

    always_comb begin
        q_fold  = (i_quot >= TURN) ? i_quot - TURN : i_quot;
        bear_in = i_tag.same ? '0 : OW'(q_fold);
    end

    // pipeline only moves while the skid is empty
    assign o_en       = !r_skid_valid;
    assign drain_skid = r_skid_valid && i_ready;
    assign take_in    = !r_skid_valid && (!r_out_valid || i_ready);
    assign load_out   = drain_skid || (take_in && i_tag.valid);
    assign load_skid  = !r_skid_valid && r_out_valid && !i_ready && i_tag.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (drain_skid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else if (take_in) begin
                r_out_valid <= i_tag.valid;
            end else if (load_skid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_bear <= drain_skid ? r_skid_bear : bear_in;
            r_out_same <= drain_skid ? r_skid_same : i_tag.same;
        end
        if (load_skid) begin
            r_skid_bear <= bear_in;
            r_skid_same <= i_tag.same;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_bearing = r_out_bear;
    assign o_same    = r_out_same;

endmodule

// File: rtl/compass_bearing_angle.sv
// compass bearing between two points: 16-step cordic atan2 pipeline with rounding divide
// path: an accepted item passes the entry register, the cordic stages, the divide registers and the output register
// throughput: one item per clock while the skid is empty; every stage is a register, the skid holds one item
// back-pressure: a held output fills the skid, which then freezes the whole pipeline
// reset: synchronous active-low i_rst_n clears all valid bits and the skid, no table init
module compass_bearing_angle (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input item stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [4*cba_pkg::FIELD_W-1:0]   i_s_tdata,  // from_x, from_y, to_x, to_y
    // result item stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [cba_pkg::OUT_W-1:0]       o_m_tdata,  // bearing
    output logic [0:0]                      o_m_tuser   // same_point
);

    // pipeline advance, tied to skid occupancy so it never depends on i_m_tready
    logic pipe_en;

    // tags and payload between the three sections
    cba_pkg::t_tag                      front_tag;
    logic signed [cba_pkg::ANG_W-1:0]   front_z;
    cba_pkg::t_tag                      div_tag;
    logic [cba_pkg::QUOT_W-1:0]         div_quot;
    logic                               same_q;

    // differences, half-turn pre-rotation and cordic micro-rotations;
    // angle accumulates in picodegrees so the result is exact to the table
    cba_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata),
        .o_tag   (front_tag),
        .o_z     (front_z)
    );

    // 90 deg minus angle mod 360, then round half up to 1/2^frac deg
    // through a reciprocal estimate and one correction step, dividing by one degree
    cba_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_tag   (front_tag),
        .i_z     (front_z),
        .o_tag   (div_tag),
        .o_quot  (div_quot)
    );

    // a rounded full turn reads as zero; coincident points force zero
    cba_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tag     (div_tag),
        .i_quot    (div_quot),
        .o_en      (pipe_en),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_bearing (o_m_tdata),
        .o_same    (same_q)
    );

    assign o_s_tready = pipe_en;
    assign o_m_tuser  = same_q;

    // a coincident pair always leaves with a zero bearing
    a_same_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == '0)
        else $error("coincident item with nonzero bearing");

    // the skid only fills behind a waiting output item
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("skid holds an item while output is empty");

    // a taken output drains the skid into the output register by the next cycle
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready && i_m_tready |=> o_s_tready && o_m_tvalid)
        else $error("skid did not drain into the output register");

endmodule

// File: tb/bearing_checker.sv
// checker for the compass bearing block: predicts each result and compares it
module bearing_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [63:0] i_s_tdata,   // from_x, from_y, to_x, to_y
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // bearing
    input  logic [0:0]  i_m_tuser,   // same_point
    output int          o_errors,
    output int          o_pending,
    output int          o_checked,
    output int          o_coincident
);

    localparam int    GUARD      = 24;
    localparam int    MAX_STEPS  = 24;
    localparam int    N_STEPS    = (cba_pkg::CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS
                                                                      : cba_pkg::CORDIC_STEPS;
    localparam int    FRAC       = cba_pkg::ANGLE_FRAC_BITS;
    localparam int    CBITS      = cba_pkg::COORD_BITS;
    localparam longint PDEG      = 64'sd1000000000000;

    // atan(2^-i) in picodegrees
    localparam longint ATAN_STEP [MAX_STEPS] = '{
        64'sd45000000000000, 64'sd26565051177078, 64'sd14036243467926, 64'sd7125016348902,
        64'sd3576334374997,  64'sd1789910608246,  64'sd895173710211,   64'sd447614170861,
        64'sd223810500369,   64'sd111905677066,   64'sd55952891894,    64'sd27976452617,
        64'sd13988227142,    64'sd6994113675,     64'sd3497056851,     64'sd1748528427,
        64'sd874264214,      64'sd437132107,      64'sd218566053,      64'sd109283027,
        64'sd54641513,       64'sd27320757,       64'sd13660378,       64'sd6830189
    };

    typedef struct {
        logic [63:0] pair;
        logic [15:0] bearing;
        logic        same;
    } t_bearing;

    t_bearing bearing_due [$];
    t_bearing want;
    int       err_count;
    int       checked;
    int       coincident;

    // low CBITS of a field, sign-extended
    function automatic longint coord_of(input logic [15:0] raw);
        longint v;
        v = longint'({48'd0, raw}) & ((64'sd1 <<< CBITS) - 1);
        if (v[CBITS-1])
            v = v - (64'sd1 <<< CBITS);
        return v;
    endfunction

    function automatic t_bearing predict_bearing(input logic [63:0] pair);
        longint fx, fy, tx, ty, dx, dy, vx, vy, acc, xs, ys, full_turn, b;
        longint unsigned scaled;
        t_bearing r;
        fx = coord_of(pair[15:0]);
        fy = coord_of(pair[31:16]);
        tx = coord_of(pair[47:32]);
        ty = coord_of(pair[63:48]);
        dx = fx - tx;
        dy = ty - fy;
        r.pair    = pair;
        r.bearing = '0;
        r.same    = 1'b0;
        if (dx == 0 && dy == 0) begin
            r.same = 1'b1;
            return r;
        end
        // left half plane: turn by 180 degrees first
        if (dx < 0) begin
            vx  = -dx;
            vy  = -dy;
            acc = 180 * PDEG;
        end else begin
            vx  = dx;
            vy  = dy;
            acc = 0;
        end
        vx = vx * (64'sd1 <<< GUARD);
        vy = vy * (64'sd1 <<< GUARD);
        for (int i = 0; i < N_STEPS; i++) begin
            xs = vx >>> i;
            ys = vy >>> i;
            // zero residue rotates counterclockwise like a negative one
            if (vy > 0) begin
                vx  = vx + ys;
                vy  = vy - xs;
                acc = acc + ATAN_STEP[i];
            end else begin
                vx  = vx - ys;
                vy  = vy + xs;
                acc = acc - ATAN_STEP[i];
            end
        end
        full_turn = 360 * PDEG;
        b = 90 * PDEG - acc;
        b = b % full_turn;
        if (b < 0)
            b = b + full_turn;
        scaled = ($unsigned(b) * (64'd1 << FRAC) + $unsigned(PDEG / 2)) / $unsigned(PDEG);
        // rounding up to a full turn wraps to zero
        if (scaled >= (64'd360 << FRAC))
            scaled = scaled - (64'd360 << FRAC);
        r.bearing = scaled[15:0];
        return r;
    endfunction

    initial begin
        err_count    = 0;
        checked      = 0;
        coincident   = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bearing_due.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                bearing_due.push_back(predict_bearing(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (bearing_due.size() == 0) begin
                    err_count++;
                    $display("%0t unexpected result: expected none actual bearing %0d same %0d",
                             $time, i_m_tdata, i_m_tuser[0]);
                end else begin
                    want = bearing_due.pop_front();
                    checked++;
                    if (want.same)
                        coincident++;
                    if (i_m_tdata !== want.bearing) begin
                        err_count++;
                        $display("%0t bearing mismatch for pair %h: expected %0d actual %0d",
                                 $time, want.pair, want.bearing, i_m_tdata);
                    end
                    if (i_m_tuser[0] !== want.same) begin
                        err_count++;
                        $display("%0t same_point mismatch for pair %h: expected %0d actual %0d",
                                 $time, want.pair, want.same, i_m_tuser[0]);
                    end
                end
            end
        end
        o_errors     <= err_count;
        o_pending    <= bearing_due.size();
        o_checked    <= checked;
        o_coincident <= coincident;
    end

endmodule

// File: tb/tb_compass_bearing_angle.sv
// testbench top for the compass bearing block: stimulus, idling, hold-off and verdict
module tb_compass_bearing_angle;

    // run sizes
    localparam int N_RANDOM    = 780;
    localparam int HOLD_CYCLES = 300;     // long receiver hold-off, fills the pipeline
    localparam int LIMIT       = 500000;  // cycle limit of the whole run
    localparam int DRAIN       = 60;      // well over the pipeline latency

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;   // from_x, from_y, to_x, to_y
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // bearing
    logic [0:0]  o_m_tuser;   // same_point

    int errors;
    int pending;
    int checked;
    int coincident;
    int sent;
    int cycles;

    // control between the stimulus and the receiver process
    bit hold_req;
    bit free_run;

    logic [15:0] px, py, qx, qy;

    always #4 i_clk = ~i_clk;

    compass_bearing_angle dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    bearing_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_coincident (coincident)
    );

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // coordinates at or near the ends of the range
    function automatic logic [15:0] extreme_coord();
        case ($urandom_range(0, 6))
            0: return 16'h8000;
            1: return 16'h8001;
            2: return 16'hffff;
            3: return 16'h0000;
            4: return 16'h0001;
            5: return 16'h7ffe;
            default: return 16'h7fff;
        endcase
    endfunction

    // offer one point pair and hold it until accepted
    task automatic offer_pair(input logic [15:0] fx, input logic [15:0] fy,
                              input logic [15:0] tx, input logic [15:0] ty);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {ty, tx, fy, fx};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        sent++;
    endtask

    // optional sender gap after an accepted item
    task automatic sender_gap();
        int g;
        g = free_run ? 0 : idle_len();
        if (g > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic directed_pair(input logic [15:0] fx, input logic [15:0] fy,
                                 input logic [15:0] tx, input logic [15:0] ty);
        offer_pair(fx, fy, tx, ty);
        sender_gap();
    endtask

    // random pair: full range, close points, extremes, axes and diagonals
    task automatic pick_pair(output logic [15:0] fx, output logic [15:0] fy,
                             output logic [15:0] tx, output logic [15:0] ty);
        int r;
        int d;
        r  = $urandom_range(0, 99);
        fx = 16'($urandom);
        fy = 16'($urandom);
        if (r < 50) begin
            tx = 16'($urandom);
            ty = 16'($urandom);
        end else if (r < 70) begin
            // close points, coincident among them
            tx = fx + 16'($urandom_range(0, 8)) - 16'd4;
            ty = fy + 16'($urandom_range(0, 8)) - 16'd4;
        end else if (r < 85) begin
            fx = extreme_coord();
            fy = extreme_coord();
            tx = extreme_coord();
            ty = extreme_coord();
        end else begin
            d = $urandom_range(0, 3);
            tx = 16'($urandom);
            ty = 16'($urandom);
            case (d)
                0: tx = fx;                     // vertical axis
                1: ty = fy;                     // horizontal axis
                2: ty = fy + (fx - tx);         // diagonal dy = dx
                default: ty = fy - (fx - tx);   // diagonal dy = -dx
            endcase
        end
    endtask

    // cycle limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycles, pending);
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random ready windows and stalls, one long hold-off on request
    initial begin
        int stall;
        int hold_cnt;
        i_m_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_m_tready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(posedge i_clk);
                hold_req = 1'b0;
            end else if (free_run) begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                stall = idle_len();
                if (stall > 0) begin
                    i_m_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    // stimulus and verdict
    initial begin
        int n;
        sent     = 0;
        cycles   = 0;
        hold_req = 1'b0;
        free_run = 1'b0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // coincident points
        directed_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        directed_pair(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        // widest differences in both directions
        directed_pair(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
        directed_pair(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        directed_pair(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        directed_pair(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        // unit steps along the axes: dx positive, dx negative, dy positive, dy negative
        directed_pair(16'h0001, 16'h0000, 16'h0000, 16'h0000);
        directed_pair(16'h0000, 16'h0000, 16'h0001, 16'h0000);
        directed_pair(16'h0000, 16'h0000, 16'h0000, 16'h0001);
        directed_pair(16'h0000, 16'h0001, 16'h0000, 16'h0000);
        // long axes
        directed_pair(16'h7fff, 16'h1234, 16'h8000, 16'h1234);
        directed_pair(16'h8000, 16'h1234, 16'h7fff, 16'h1234);
        directed_pair(16'h4321, 16'h8000, 16'h4321, 16'h7fff);
        directed_pair(16'h4321, 16'h7fff, 16'h4321, 16'h8000);
        // diagonals, where a cordic step meets a zero vertical residue
        directed_pair(16'h0001, 16'h0000, 16'h0000, 16'h0001);
        directed_pair(16'h0000, 16'h0000, 16'h0001, 16'h0001);
        directed_pair(16'h0000, 16'h0001, 16'h0001, 16'h0000);
        directed_pair(16'h0001, 16'h0001, 16'h0000, 16'h0000);
        directed_pair(16'h0100, 16'h0000, 16'h0000, 16'h0100);
        // nearly due north from both sides, where rounding can reach a full turn
        directed_pair(16'h0000, 16'h8000, 16'h0001, 16'h7fff);
        directed_pair(16'h0001, 16'h8000, 16'h0000, 16'h7fff);
        directed_pair(16'h0000, 16'h0000, 16'h0001, 16'h7fff);
        // all ones against all zeros
        directed_pair(16'hffff, 16'hffff, 16'h0000, 16'h0000);

        // random part with a burst stretch and one long receiver hold-off
        for (n = 0; n < N_RANDOM; n++) begin
            if (n == 200)
                free_run = 1'b1;     // no idling on either side for a while
            if (n == 300)
                free_run = 1'b0;
            if (n == 400)
                hold_req = 1'b1;     // receiver holds off, sender keeps offering
            pick_pair(px, py, qx, qy);
            offer_pair(px, py, qx, qy);
            if (n < 400 || n >= 520)
                sender_gap();
        end
        i_s_tvalid <= 1'b0;
        // let the count of due results take in the last accepted item
        @(posedge i_clk);

        // drain: every expected result, then quiet cycles well past the pipeline latency
        while (pending != 0 || hold_req)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("covered %0d point pairs: axes, diagonals, extremes, close and random points",
                 sent);
        $display("%0d results compared, %0d coincident, with one %0d-cycle output hold-off",
                 checked, coincident, HOLD_CYCLES);
        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
